>>> hw/rtl/mfmd_pkg.sv
// Shared types, register codes and helpers for the multiturn feedback decoder.
// No dependencies; the top level, mfmd_track and mfmd_scale refer to it by scoped names.
`timescale 1ns / 1ps

package mfmd_pkg;

   localparam int IdW      = 11;
   localparam int DlcW     = 4;
   localparam int WordW    = 16;
   localparam int TotalW   = 32;
   localparam int CsrIdxW  = 8;
   localparam int CsrDataW = 24;

   localparam logic [DlcW-1:0] DLC_FEEDBACK = 4'd8;
   localparam int FeedbackIds = 4;

   localparam logic [10:0] ID_BASE_RESET        = 11'd517;
   localparam logic [23:0] ANGLE_SCALE_RESET    = 24'd7372800;
   localparam logic [16:0] VELOCITY_SCALE_RESET = 17'd65536;
   localparam logic [14:0] CURRENT_SCALE_RESET  = 15'd3000;

   localparam int AngleShift    = 24;
   localparam int VelocityShift = 16;
   localparam int CurrentShift  = 14;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_ID_BASE        = 8'd0,
      CSR_ANGLE_SCALE    = 8'd1,
      CSR_VELOCITY_SCALE = 8'd2,
      CSR_CURRENT_SCALE  = 8'd3
   } csr_index_type;

   typedef struct packed {
      logic [23:0] angle_scale;
      logic [16:0] velocity_scale;
      logic [14:0] current_scale;
   } scale_cfg_type;

   typedef struct packed {
      logic               accepted;
      logic [1:0]         motor_index;
      logic signed [15:0] turn_count;
      logic signed [15:0] position;
      logic signed [15:0] speed;
      logic signed [15:0] current;
   } track_word_type;

   // Shift right truncating toward zero, then clamp to 16-bit signed.
   function automatic logic signed [15:0] trunc_sat16(input logic signed [63:0] p,
                                                       input int shift);
      logic signed [63:0] bias;
      logic signed [63:0] q;
      bias = p[63] ? ((64'sd1 <<< shift) - 64'sd1) : 64'sd0;
      q    = (p + bias) >>> shift;
      if (q > 64'sd32767) begin
         trunc_sat16 = 16'sh7fff;
      end else if (q < -64'sd32768) begin
         trunc_sat16 = 16'sh8000;
      end else begin
         trunc_sat16 = q[15:0];
      end
   endfunction

endpackage

>>> hw/rtl/mfmd_if.sv
// Channel interfaces of the decoder: feedback frame in, decoded word out, CSR writes.
// Depends on nothing but the standard types.
`timescale 1ns / 1ps

interface mfmd_req_if;
   logic        valid;
   logic        ready;
   logic [10:0] frame_id;
   logic [3:0]  data_length;
   logic [15:0] position_word;
   logic [15:0] speed_word;
   logic [15:0] current_word;

   modport source(output valid, frame_id, data_length, position_word, speed_word,
                  current_word, input ready);
   modport sink(input valid, frame_id, data_length, position_word, speed_word,
                current_word, output ready);
endinterface

interface mfmd_rsp_if;
   logic               valid;
   logic               ready;
   logic               accepted;
   logic [1:0]         motor_index;
   logic signed [15:0] turn_count;
   logic signed [31:0] total_position;
   logic signed [15:0] angle_tenth_deg;
   logic signed [15:0] velocity_rpm;
   logic signed [15:0] current_ma;

   modport source(output valid, accepted, motor_index, turn_count, total_position,
                  angle_tenth_deg, velocity_rpm, current_ma, input ready);
   modport sink(input valid, accepted, motor_index, turn_count, total_position,
                angle_tenth_deg, velocity_rpm, current_ma, output ready);
endinterface

interface mfmd_csr_if;
   logic        valid;
   logic        ready;
   logic [7:0]  index;
   logic [23:0] data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

>>> hw/rtl/motor_feedback_multiturn_decoder.sv
// Top level of the multiturn feedback decoder: CSR bank, tracker and scaler.
// Depends on mfmd_pkg, mfmd_if, mfmd_track and mfmd_scale.
//
//   channel   dir   word
//   req_chan  in    one received feedback frame (id, length, three data words)
//   rsp_chan  out   decoded word: accept flag, motor, turns, total, angle, rpm, mA
//   csr_chan  in    register write: index, data (always ready)
//
// One frame per cycle while rsp_chan is ready.
// Motor state (last position, turns) is updated as a frame enters the track word register,
// so frames for the same motor may follow each other in consecutive cycles.
// Reset clears all valid bits, motor state and registers to their defaults.
// A stalled rsp_chan backs up through the five-register pipeline before req_chan stalls.
`timescale 1ns / 1ps

module motor_feedback_multiturn_decoder #(
   parameter int MOTORS         = 4,
   parameter int ENCODER_COUNTS = 8192
) (
   input logic        clock,
   input logic        reset,
   mfmd_req_if.sink   req_chan,
   mfmd_rsp_if.source rsp_chan,
   mfmd_csr_if.sink   csr_chan
);

   logic [10:0]              id_base_ff;
   mfmd_pkg::scale_cfg_type  cfg_ff;
   mfmd_pkg::track_word_type track_word;
   logic                     track_valid;
   logic                     track_ready;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         id_base_ff            <= mfmd_pkg::ID_BASE_RESET;
         cfg_ff.angle_scale    <= mfmd_pkg::ANGLE_SCALE_RESET;
         cfg_ff.velocity_scale <= mfmd_pkg::VELOCITY_SCALE_RESET;
         cfg_ff.current_scale  <= mfmd_pkg::CURRENT_SCALE_RESET;
      end else if (csr_chan.valid) begin
         case (mfmd_pkg::csr_index_type'(csr_chan.index))
            mfmd_pkg::CSR_ID_BASE: begin
               id_base_ff <= csr_chan.data[10:0];
            end
            mfmd_pkg::CSR_ANGLE_SCALE: begin
               cfg_ff.angle_scale <= csr_chan.data[23:0];
            end
            mfmd_pkg::CSR_VELOCITY_SCALE: begin
               cfg_ff.velocity_scale <= csr_chan.data[16:0];
            end
            mfmd_pkg::CSR_CURRENT_SCALE: begin
               cfg_ff.current_scale <= csr_chan.data[14:0];
            end
            default: begin
            end
         endcase
      end
   end

   mfmd_track #(
      .MOTORS         (MOTORS),
      .ENCODER_COUNTS (ENCODER_COUNTS)
   ) u_track (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .id_base     (id_base_ff),
      .track_word  (track_word),
      .track_valid (track_valid),
      .track_ready (track_ready)
   );

   mfmd_scale #(
      .ENCODER_COUNTS (ENCODER_COUNTS)
   ) u_scale (
      .clock       (clock),
      .reset       (reset),
      .track_word  (track_word),
      .track_valid (track_valid),
      .track_ready (track_ready),
      .cfg         (cfg_ff),
      .rsp_chan    (rsp_chan)
   );

endmodule

>>> hw/rtl/mfmd_track.sv
// Frame input register, identifier check and per-motor turn tracking.
// Depends on mfmd_pkg and mfmd_req_if.
`timescale 1ns / 1ps

module mfmd_track #(
   parameter int MOTORS         = 4,
   parameter int ENCODER_COUNTS = 8192
) (
   input  logic                    clock,
   input  logic                    reset,
   mfmd_req_if.sink                req_chan,
   input  logic [10:0]             id_base,
   output mfmd_pkg::track_word_type track_word,
   output logic                    track_valid,
   input  logic                    track_ready
);

   localparam int MidxW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
   localparam int Half  = ENCODER_COUNTS / 2;

   logic        in_valid_ff;
   logic [10:0] id_ff;
   logic [3:0]  dlc_ff;
   logic signed [15:0] pos_ff;
   logic signed [15:0] spd_ff;
   logic signed [15:0] cur_ff;

   logic signed [15:0] prev_ff  [MOTORS];
   logic signed [15:0] turns_ff [MOTORS];

   mfmd_pkg::track_word_type word_ff;
   mfmd_pkg::track_word_type word_in;
   logic                     valid_ff;

   logic               advance;
   logic               in_ready;
   logic [10:0]        offset;
   logic               hit;
   logic [MidxW-1:0]   midx;
   logic signed [15:0] prev;
   logic signed [15:0] turns_old;
   logic signed [15:0] turns_new;
   logic signed [16:0] diff;

   assign advance        = !valid_ff || track_ready;
   assign in_ready       = !in_valid_ff || advance;
   assign req_chan.ready = in_ready;
   assign track_word     = word_ff;
   assign track_valid    = valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_ready) begin
         in_valid_ff <= req_chan.valid;
      end
      if (in_ready && req_chan.valid) begin
         id_ff  <= req_chan.frame_id;
         dlc_ff <= req_chan.data_length;
         pos_ff <= req_chan.position_word;
         spd_ff <= req_chan.speed_word;
         cur_ff <= req_chan.current_word;
      end
   end

   always_comb begin
      offset = id_ff - id_base;
      hit    = (dlc_ff == mfmd_pkg::DLC_FEEDBACK) && (id_ff >= id_base) &&
               (offset < 11'(mfmd_pkg::FeedbackIds)) && (offset < 11'(MOTORS));
      midx      = offset[MidxW-1:0];
      prev      = prev_ff[midx];
      turns_old = turns_ff[midx];
      diff      = 17'(pos_ff) - 17'(prev);
      turns_new = turns_old;
      if (int'(diff) > Half) begin
         if (turns_old != 16'sh8000) begin
            turns_new = turns_old - 16'sd1;
         end
      end else if (int'(diff) < -Half) begin
         if (turns_old != 16'sh7fff) begin
            turns_new = turns_old + 16'sd1;
         end
      end
      word_in.accepted    = hit;
      word_in.motor_index = hit ? offset[1:0] : 2'd0;
      word_in.turn_count  = hit ? turns_new : 16'sd0;
      word_in.position    = hit ? pos_ff : 16'sd0;
      word_in.speed       = hit ? spd_ff : 16'sd0;
      word_in.current     = hit ? cur_ff : 16'sd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < MOTORS; i++) begin
            prev_ff[i]  <= 16'sd0;
            turns_ff[i] <= 16'sd0;
         end
      end else if (advance) begin
         valid_ff <= in_valid_ff;
         if (in_valid_ff && hit) begin
            prev_ff[midx]  <= pos_ff;
            turns_ff[midx] <= turns_new;
         end
      end
      if (advance) begin
         word_ff <= word_in;
      end
   end

endmodule

>>> hw/rtl/mfmd_scale.sv
// Total position, fixed-point scaling and saturation, ending in the result register.
// Depends on mfmd_pkg and mfmd_rsp_if.
`timescale 1ns / 1ps

module mfmd_scale #(
   parameter int ENCODER_COUNTS = 8192
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mfmd_pkg::track_word_type track_word,
   input  logic                     track_valid,
   output logic                     track_ready,
   input  mfmd_pkg::scale_cfg_type  cfg,
   mfmd_rsp_if.source               rsp_chan
);

   // stage: total position and speed/current products
   logic               v3_ff;
   logic               acc3_ff;
   logic [1:0]         m3_ff;
   logic signed [15:0] t3_ff;
   logic signed [31:0] total3_ff;
   logic signed [33:0] vprod3_ff;
   logic signed [31:0] cprod3_ff;

   // stage: angle product, speed/current results
   logic               v4_ff;
   logic               acc4_ff;
   logic [1:0]         m4_ff;
   logic signed [15:0] t4_ff;
   logic signed [31:0] total4_ff;
   logic signed [56:0] aprod4_ff;
   logic signed [15:0] vel4_ff;
   logic signed [15:0] cur4_ff;

   // result register
   logic               vo_ff;
   logic               acco_ff;
   logic [1:0]         mo_ff;
   logic signed [15:0] to_ff;
   logic signed [31:0] totalo_ff;
   logic signed [15:0] ango_ff;
   logic signed [15:0] velo_ff;
   logic signed [15:0] curo_ff;

   logic               rdy_out;
   logic               rdy4;
   logic               rdy3;
   logic signed [33:0] total_wide;
   logic signed [31:0] total_in;

   assign rdy_out     = !vo_ff || rsp_chan.ready;
   assign rdy4        = !v4_ff || rdy_out;
   assign rdy3        = !v3_ff || rdy4;
   assign track_ready = rdy3;

   always_comb begin
      total_wide = 34'(track_word.turn_count) * 34'(ENCODER_COUNTS) +
                   34'(track_word.position);
      if (total_wide > 34'sd2147483647) begin
         total_in = 32'sh7fffffff;
      end else if (total_wide < -34'sd2147483648) begin
         total_in = 32'sh80000000;
      end else begin
         total_in = total_wide[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (rdy3) begin
            v3_ff <= track_valid;
         end
         if (rdy4) begin
            v4_ff <= v3_ff;
         end
         if (rdy_out) begin
            vo_ff <= v4_ff;
         end
      end
      if (rdy3) begin
         acc3_ff   <= track_word.accepted;
         m3_ff     <= track_word.motor_index;
         t3_ff     <= track_word.turn_count;
         total3_ff <= total_in;
         vprod3_ff <= track_word.speed * $signed({1'b0, cfg.velocity_scale});
         cprod3_ff <= track_word.current * $signed({1'b0, cfg.current_scale});
      end
      if (rdy4) begin
         acc4_ff   <= acc3_ff;
         m4_ff     <= m3_ff;
         t4_ff     <= t3_ff;
         total4_ff <= total3_ff;
         aprod4_ff <= total3_ff * $signed({1'b0, cfg.angle_scale});
         vel4_ff   <= mfmd_pkg::trunc_sat16(64'(vprod3_ff), mfmd_pkg::VelocityShift);
         cur4_ff   <= mfmd_pkg::trunc_sat16(64'(cprod3_ff), mfmd_pkg::CurrentShift);
      end
      if (rdy_out) begin
         acco_ff   <= acc4_ff;
         mo_ff     <= m4_ff;
         to_ff     <= t4_ff;
         totalo_ff <= total4_ff;
         ango_ff   <= mfmd_pkg::trunc_sat16(64'(aprod4_ff), mfmd_pkg::AngleShift);
         velo_ff   <= vel4_ff;
         curo_ff   <= cur4_ff;
      end
   end

   assign rsp_chan.valid           = vo_ff;
   assign rsp_chan.accepted        = acco_ff;
   assign rsp_chan.motor_index     = mo_ff;
   assign rsp_chan.turn_count      = to_ff;
   assign rsp_chan.total_position  = totalo_ff;
   assign rsp_chan.angle_tenth_deg = ango_ff;
   assign rsp_chan.velocity_rpm    = velo_ff;
   assign rsp_chan.current_ma      = curo_ff;

endmodule
